@@ hw/rtl/desa2_pkg.sv @@
// Package for the DESA-2 frequency and amplitude estimator.
// Holds widths, saturation limits and the sequencer state type.
// Has no dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package desa2_pkg;

  // Sample and fixed-point format.
  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 16;
  localparam int ROOT_FRAC_BITS = 7;

  // Result field widths.
  localparam int FREQ_W = 32;
  localparam int AMP_W  = 40;

  // Teager-energy term accumulators, with headroom for the sums of products.
  localparam int ACC_W = 2 * SAMPLE_BITS + 4;
  // Partial remainder of the shared restoring step.
  localparam int REM_W = ACC_W + 1;
  // Radicand and root of the square root.
  localparam int SQ_W  = ACC_W + 2 * ROOT_FRAC_BITS;
  localparam int RT_W  = SQ_W / 2;
  // Fraction bits that the amplitude division produces.
  localparam int AMP_K = FRAC_BITS + ROOT_FRAC_BITS;
  // Number of products per window.
  localparam int NUM_PROD = 7;
  localparam int MCNT_W   = $clog2(NUM_PROD);
  localparam int CNT_W    = $clog2(AMP_W);

  // Saturation limits, magnitudes.
  localparam logic [FREQ_W-1:0] FREQ_POS_CAP = {1'b0, {(FREQ_W-1){1'b1}}};
  localparam logic [FREQ_W-1:0] FREQ_NEG_CAP = {1'b1, {(FREQ_W-1){1'b0}}};
  localparam logic [AMP_W-1:0]  AMP_POS_CAP  = {1'b0, {(AMP_W-1){1'b1}}};
  localparam logic [AMP_W-1:0]  AMP_NEG_CAP  = {1'b1, {(AMP_W-1){1'b0}}};

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_TERM,
    ST_SQRT,
    ST_AINIT,
    ST_ADIV,
    ST_FINIT,
    ST_FDIV,
    ST_FIN
  } state_t;

endpackage

@@ hw/rtl/desa2_if.sv @@
// Valid/ready channel interfaces for the estimator's sample and result streams.
// Depends on desa2_pkg for the payload widths.
`timescale 1ns / 1ps

interface desa2_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [desa2_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface desa2_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [desa2_pkg::FREQ_W-1:0] freq_ratio;
  logic signed [desa2_pkg::AMP_W-1:0]  amplitude;
  logic                                div_zero;
  logic                                bad_energy;

  modport source (output valid, output freq_ratio, output amplitude,
                  output div_zero, output bad_energy, input ready);
  modport sink   (input valid, input freq_ratio, input amplitude,
                  input div_zero, input bad_energy, output ready);
endinterface

@@ hw/rtl/desa2_sub_unit.sv @@
// Shared compare-and-subtract unit used by every square root and division step.
// Depends on desa2_pkg for the remainder width.
`timescale 1ns / 1ps

module desa2_sub_unit (
  input  logic [desa2_pkg::REM_W-1:0] a,
  input  logic [desa2_pkg::REM_W-1:0] b,
  output logic [desa2_pkg::REM_W-1:0] diff,
  output logic                        ge
);

  logic [desa2_pkg::REM_W:0] wide;

  // One extra bit catches the borrow: no borrow means a >= b.
  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[desa2_pkg::REM_W];
  assign diff = wide[desa2_pkg::REM_W-1:0];

endmodule

@@ hw/rtl/desa2_frequency_amplitude_estimator_core.sv @@
// Top level of the DESA-2 frequency and amplitude estimator.
// Depends on desa2_pkg, desa2_if.sv and desa2_sub_unit.
//
// Usage:
//   Each transfer on in_chan carries one signed sample. The sample completes a
//   five-sample window with the four previous samples held in a delay line,
//   and produces exactly one transfer on out_chan: freq_ratio (n/d, Q16.16),
//   amplitude (2*PSI_X/sqrt(PSI_Y), Q24.16), div_zero and bad_energy.
//   in_chan.ready is high only while the sequencer is idle. From the sample
//   transfer to a valid result, the sequencer forms seven products on the
//   shared multiplier, then takes 25 root steps, 40 amplitude division steps
//   and 32 frequency division steps, all on one shared subtractor, plus setup
//   states; a zero denominator or bad energy skips the steps that need it. A
//   quotient found to saturate skips its steps. The next sample can be taken
//   once the sequencer is back in idle after the result is loaded.
//   The result sits in an output register; a new sample is accepted while
//   it waits, and if the receiver stalls long enough the sequencer holds in
//   its final state until the register frees.
//   Reset (rst_n low at a clock edge) clears the delay line to zero, drops
//   out_chan.valid and returns the sequencer to idle.
`timescale 1ns / 1ps

module desa2_frequency_amplitude_estimator_core (
  input  logic         clk,
  input  logic         rst_n,
  desa2_in_if.sink     in_chan,
  desa2_out_if.source  out_chan
);

  localparam int SB    = desa2_pkg::SAMPLE_BITS;
  localparam int ACC_W = desa2_pkg::ACC_W;
  localparam int REM_W = desa2_pkg::REM_W;
  localparam int SQ_W  = desa2_pkg::SQ_W;
  localparam int RT_W  = desa2_pkg::RT_W;
  localparam int AMP_W = desa2_pkg::AMP_W;
  localparam int FQ_W  = desa2_pkg::FREQ_W;
  localparam int CNT_W = desa2_pkg::CNT_W;
  localparam int MC_W  = desa2_pkg::MCNT_W;

  desa2_pkg::state_t state_r, state_nxt;

  // Delay line and current sample.
  logic signed [SB-1:0] win_r [4];
  logic signed [SB-1:0] win_nxt [4];
  logic signed [SB-1:0] x4_r, x4_nxt;

  // Term accumulators.
  logic [MC_W-1:0]         mcnt_r, mcnt_nxt;
  logic signed [ACC_W-1:0] dd_r, dd_nxt, psx_r, psx_nxt, e_r, e_nxt;

  // Per-item results of the term setup.
  logic             dz_r, dz_nxt, be_r, be_nxt, negf_r, negf_nxt, nega_r, nega_nxt;
  logic [ACC_W-1:0] magn_r, magn_nxt, maga_r, maga_nxt, magd_r, magd_nxt;

  // Shared iteration registers.
  logic [SQ_W-1:0]  sqv_r, sqv_nxt;
  logic [RT_W-1:0]  root_r, root_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ACC_W-1:0] divs_r, divs_nxt;
  logic [AMP_W-1:0] q_r, q_nxt, low_r, low_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sat_r, sat_nxt;
  logic [AMP_W-1:0] ampres_r, ampres_nxt;

  // Output register.
  logic                    oval_r, oval_nxt;
  logic signed [FQ_W-1:0]  ofreq_r, ofreq_nxt;
  logic signed [AMP_W-1:0] oamp_r, oamp_nxt;
  logic                    odz_r, odz_nxt, obe_r, obe_nxt;

  logic in_xfer, out_free;

  // Multiplier operands and product.
  logic signed [SB-1:0]    ma, mb;
  logic signed [2*SB-1:0]  prod;
  logic signed [ACC_W-1:0] prod_ext;

  // Term setup values.
  logic signed [ACC_W-1:0] n_c, psy_c;

  // Division setup values.
  logic [ACC_W+AMP_W-1:0] wide_a;
  logic [ACC_W+FQ_W-1:0]  wide_f;

  // Shared unit ports.
  logic [REM_W-1:0] sub_a, sub_b, sub_diff;
  logic             sub_ge;

  // Result formatting.
  logic [FQ_W-1:0]  capf, magf, freq_c;
  logic [AMP_W-1:0] capa, maga_q, amp_c;

  assign in_chan.ready = (state_r == desa2_pkg::ST_IDLE);
  assign in_xfer       = in_chan.valid & in_chan.ready;
  assign out_free      = ~oval_r | out_chan.ready;

  assign out_chan.valid      = oval_r;
  assign out_chan.freq_ratio = ofreq_r;
  assign out_chan.amplitude  = oamp_r;
  assign out_chan.div_zero   = odz_r;
  assign out_chan.bad_energy = obe_r;

  // Shared compare-and-subtract unit.
  desa2_sub_unit u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Operand selection for the shared multiplier, one product per cycle.
  always_comb begin
    case (mcnt_r)
      3'd0:    begin ma = win_r[2]; mb = win_r[2]; end
      3'd1:    begin ma = win_r[1]; mb = win_r[3]; end
      3'd2:    begin ma = win_r[0]; mb = x4_r;     end
      3'd3:    begin ma = win_r[1]; mb = win_r[1]; end
      3'd4:    begin ma = win_r[0]; mb = win_r[2]; end
      3'd5:    begin ma = win_r[3]; mb = win_r[3]; end
      3'd6:    begin ma = win_r[2]; mb = x4_r;     end
      default: begin ma = '0;       mb = '0;       end
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = ACC_W'(prod);

  // Setup values for the terms and the two divisions.
  assign n_c    = psx_r - e_r;
  assign psy_c  = e_r + psx_r;
  assign wide_a = {maga_r, {AMP_W{1'b0}}} >> (AMP_W - desa2_pkg::AMP_K);
  assign wide_f = {magn_r, {FQ_W{1'b0}}} >> (FQ_W - desa2_pkg::FRAC_BITS);

  // Saturated, signed results.
  always_comb begin
    capf   = negf_r ? desa2_pkg::FREQ_NEG_CAP : desa2_pkg::FREQ_POS_CAP;
    magf   = (sat_r || (q_r[FQ_W-1:0] > capf)) ? capf : q_r[FQ_W-1:0];
    freq_c = dz_r ? '0 : (negf_r ? (~magf + 1'b1) : magf);
    capa   = nega_r ? desa2_pkg::AMP_NEG_CAP : desa2_pkg::AMP_POS_CAP;
    maga_q = (sat_r || (q_r > capa)) ? capa : q_r;
    amp_c  = be_r ? '0 : (nega_r ? (~maga_q + 1'b1) : maga_q);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      desa2_pkg::ST_IDLE:  if (in_xfer) state_nxt = desa2_pkg::ST_MUL;
      desa2_pkg::ST_MUL:   if (mcnt_r == MC_W'(desa2_pkg::NUM_PROD - 1))
                             state_nxt = desa2_pkg::ST_TERM;
      desa2_pkg::ST_TERM:  state_nxt = (psy_c > 0) ? desa2_pkg::ST_SQRT
                                                   : desa2_pkg::ST_FINIT;
      desa2_pkg::ST_SQRT:  if (cnt_r == CNT_W'(RT_W - 1)) state_nxt = desa2_pkg::ST_AINIT;
      desa2_pkg::ST_AINIT: state_nxt = sub_ge ? desa2_pkg::ST_FINIT : desa2_pkg::ST_ADIV;
      desa2_pkg::ST_ADIV:  if (cnt_r == CNT_W'(AMP_W - 1)) state_nxt = desa2_pkg::ST_FINIT;
      desa2_pkg::ST_FINIT: begin
        if (dz_r || sub_ge) state_nxt = desa2_pkg::ST_FIN;
        else                state_nxt = desa2_pkg::ST_FDIV;
      end
      desa2_pkg::ST_FDIV:  if (cnt_r == CNT_W'(FQ_W - 1)) state_nxt = desa2_pkg::ST_FIN;
      desa2_pkg::ST_FIN:   if (out_free) state_nxt = desa2_pkg::ST_IDLE;
      default:             state_nxt = desa2_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    win_nxt    = win_r;
    x4_nxt     = x4_r;
    mcnt_nxt   = mcnt_r;
    dd_nxt     = dd_r;
    psx_nxt    = psx_r;
    e_nxt      = e_r;
    dz_nxt     = dz_r;
    be_nxt     = be_r;
    negf_nxt   = negf_r;
    nega_nxt   = nega_r;
    magn_nxt   = magn_r;
    maga_nxt   = maga_r;
    magd_nxt   = magd_r;
    sqv_nxt    = sqv_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    divs_nxt   = divs_r;
    q_nxt      = q_r;
    low_nxt    = low_r;
    cnt_nxt    = cnt_r;
    sat_nxt    = sat_r;
    ampres_nxt = ampres_r;
    oval_nxt   = oval_r;
    ofreq_nxt  = ofreq_r;
    oamp_nxt   = oamp_r;
    odz_nxt    = odz_r;
    obe_nxt    = obe_r;
    sub_a      = '0;
    sub_b      = '0;

    // The receiver takes the waiting result.
    if (oval_r && out_chan.ready) oval_nxt = 1'b0;

    case (state_r)
      desa2_pkg::ST_IDLE: begin
        if (in_xfer) begin
          x4_nxt   = in_chan.sample;
          mcnt_nxt = '0;
          dd_nxt   = '0;
          psx_nxt  = '0;
          e_nxt    = '0;
        end
      end

      // Accumulate one product into the terms it belongs to.
      desa2_pkg::ST_MUL: begin
        mcnt_nxt = mcnt_r + 1'b1;
        case (mcnt_r)
          3'd0:    begin dd_nxt = dd_r + prod_ext; psx_nxt = psx_r + prod_ext; end
          3'd1:    dd_nxt  = dd_r - prod_ext;
          3'd2:    psx_nxt = psx_r - prod_ext;
          3'd3:    e_nxt   = e_r + prod_ext;
          3'd4:    e_nxt   = e_r - prod_ext;
          3'd5:    e_nxt   = e_r + prod_ext;
          3'd6:    e_nxt   = e_r - prod_ext;
          default: ;
        endcase
      end

      // Form n and PSI_Y, the flags and the magnitudes, and shift the window.
      desa2_pkg::ST_TERM: begin
        dz_nxt   = (dd_r == '0);
        be_nxt   = ~(psy_c > 0);
        negf_nxt = n_c[ACC_W-1] ^ dd_r[ACC_W-1];
        nega_nxt = psx_r[ACC_W-1];
        magn_nxt = n_c[ACC_W-1] ? ACC_W'(-n_c) : ACC_W'(n_c);
        maga_nxt = (psx_r[ACC_W-1] ? ACC_W'(-psx_r) : ACC_W'(psx_r)) << 1;
        magd_nxt = (dd_r[ACC_W-1] ? ACC_W'(-dd_r) : ACC_W'(dd_r)) << 1;
        sqv_nxt  = {psy_c, {(2 * desa2_pkg::ROOT_FRAC_BITS){1'b0}}};
        root_nxt = '0;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = win_r[3];
        win_nxt[3] = x4_r;
      end

      // One root digit per cycle.
      desa2_pkg::ST_SQRT: begin
        sub_a   = {rem_r[REM_W-3:0], sqv_r[SQ_W-1 -: 2]};
        sub_b   = {{(REM_W-RT_W-2){1'b0}}, root_r, 2'b01};
        sqv_nxt = sqv_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (sub_ge) begin
          rem_nxt  = sub_diff;
          root_nxt = {root_r[RT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sub_a;
          root_nxt = {root_r[RT_W-2:0], 1'b0};
        end
      end

      // Amplitude division setup; a too-large leading part saturates.
      desa2_pkg::ST_AINIT: begin
        sub_a    = {1'b0, wide_a[ACC_W+AMP_W-1:AMP_W]};
        sub_b    = {{(REM_W-RT_W){1'b0}}, root_r};
        divs_nxt = {{(ACC_W-RT_W){1'b0}}, root_r};
        rem_nxt  = sub_a;
        low_nxt  = wide_a[AMP_W-1:0];
        q_nxt    = '0;
        cnt_nxt  = '0;
        sat_nxt  = sub_ge;
      end

      // Restoring division, one quotient bit per cycle.
      desa2_pkg::ST_ADIV, desa2_pkg::ST_FDIV: begin
        sub_a   = {rem_r[REM_W-2:0], low_r[AMP_W-1]};
        sub_b   = {1'b0, divs_r};
        low_nxt = low_r << 1;
        q_nxt   = {q_r[AMP_W-2:0], sub_ge};
        rem_nxt = sub_ge ? sub_diff : sub_a;
        cnt_nxt = cnt_r + 1'b1;
      end

      // Latch the amplitude, then set up the frequency division.
      desa2_pkg::ST_FINIT: begin
        ampres_nxt = amp_c;
        sub_a      = {1'b0, wide_f[ACC_W+FQ_W-1:FQ_W]};
        sub_b      = {1'b0, magd_r};
        divs_nxt   = magd_r;
        rem_nxt    = sub_a;
        low_nxt    = {wide_f[FQ_W-1:0], {(AMP_W-FQ_W){1'b0}}};
        q_nxt      = '0;
        cnt_nxt    = '0;
        sat_nxt    = sub_ge;
      end

      // Load the output register once it is free.
      desa2_pkg::ST_FIN: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          ofreq_nxt = freq_c;
          oamp_nxt  = ampres_r;
          odz_nxt   = dz_r;
          obe_nxt   = be_r;
        end
      end

      default: ;
    endcase
  end

  // Control state and delay line take reset; payload registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= desa2_pkg::ST_IDLE;
      oval_r  <= 1'b0;
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      win_r   <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x4_r     <= x4_nxt;
    mcnt_r   <= mcnt_nxt;
    dd_r     <= dd_nxt;
    psx_r    <= psx_nxt;
    e_r      <= e_nxt;
    dz_r     <= dz_nxt;
    be_r     <= be_nxt;
    negf_r   <= negf_nxt;
    nega_r   <= nega_nxt;
    magn_r   <= magn_nxt;
    maga_r   <= maga_nxt;
    magd_r   <= magd_nxt;
    sqv_r    <= sqv_nxt;
    root_r   <= root_nxt;
    rem_r    <= rem_nxt;
    divs_r   <= divs_nxt;
    q_r      <= q_nxt;
    low_r    <= low_nxt;
    cnt_r    <= cnt_nxt;
    sat_r    <= sat_nxt;
    ampres_r <= ampres_nxt;
    ofreq_r  <= ofreq_nxt;
    oamp_r   <= oamp_nxt;
    odz_r    <= odz_nxt;
    obe_r    <= obe_nxt;
  end

endmodule

@@ bench/desa2_estimate_checker.sv @@
// Checker for the DESA-2 estimator: follows every sample transfer, predicts the result
// from its own copy of the delay line and compares each result transfer field by field.
// Depends on desa2_pkg and the channel interfaces in desa2_if.sv.
`timescale 1ns / 1ps

module desa2_estimate_checker (
  input  logic   clk,
  input  logic   rst_n,
  desa2_in_if    in_chan,
  desa2_out_if   out_chan,
  output int     fail_count,
  output int     pending_count
);

  typedef struct {
    logic signed [desa2_pkg::FREQ_W-1:0] freq_ratio;
    logic signed [desa2_pkg::AMP_W-1:0]  amplitude;
    logic                                div_zero;
    logic                                bad_energy;
  } estimate_t;

  estimate_t   estimate_q[$];
  longint      window[4];

  // Fixed-point quotient floor(a * 2^k / b), clamped to cap.
  function automatic logic [63:0] frac_quotient(logic [63:0] a, logic [63:0] b, int k,
                                                logic [63:0] cap);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] acc;
    q = a / b;
    r = a % b;
    if (q > (cap >> k)) return cap;
    acc = q << k;
    for (int i = 0; i < k; i++) begin
      r = r << 1;
      if (r >= b) begin
        r = r - b;
        acc[k-1-i] = 1'b1;
      end
    end
    return (acc > cap) ? cap : acc;
  endfunction

  // Integer square root, floor.
  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Teager-energy terms of the window x0..x4 and the two quotients.
  function automatic estimate_t predict_estimate(longint x0, longint x1, longint x2,
                                                 longint x3, longint x4);
    estimate_t   est;
    longint      den;
    longint      psi_x;
    longint      energy;
    longint      num;
    longint      psi_y;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] root;
    den    = 2 * (x2 * x2 - x1 * x3);
    psi_x  = x2 * x2 - x0 * x4;
    energy = (x1 * x1 - x0 * x2) + (x3 * x3 - x2 * x4);
    num    = psi_x - energy;
    psi_y  = energy + psi_x;
    est.freq_ratio = '0;
    est.amplitude  = '0;
    est.div_zero   = (den == 0);
    est.bad_energy = (psi_y <= 0);
    if (den != 0) begin
      neg = (num < 0) != (den < 0);
      mag = frac_quotient(magnitude(num), magnitude(den), desa2_pkg::FRAC_BITS,
                          neg ? 64'(desa2_pkg::FREQ_NEG_CAP) : 64'(desa2_pkg::FREQ_POS_CAP));
      est.freq_ratio = neg ? desa2_pkg::FREQ_W'(-mag) : desa2_pkg::FREQ_W'(mag);
    end
    if (psi_y > 0) begin
      neg  = psi_x < 0;
      root = int_root(64'(psi_y) << (2 * desa2_pkg::ROOT_FRAC_BITS));
      mag  = frac_quotient(2 * magnitude(psi_x), root, desa2_pkg::AMP_K,
                           neg ? 64'(desa2_pkg::AMP_NEG_CAP) : 64'(desa2_pkg::AMP_POS_CAP));
      est.amplitude = neg ? desa2_pkg::AMP_W'(-mag) : desa2_pkg::AMP_W'(mag);
    end
    return est;
  endfunction

  // Predict on each sample transfer, compare on each result transfer.
  always @(posedge clk) begin
    estimate_t exp_est;
    longint    x4;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) window[i] = 0;
      estimate_q.delete();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        x4 = longint'($signed(in_chan.sample));
        estimate_q.push_back(predict_estimate(window[0], window[1], window[2],
                                              window[3], x4));
        window[0] = window[1];
        window[1] = window[2];
        window[2] = window[3];
        window[3] = x4;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (estimate_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_count++;
        end else begin
          exp_est = estimate_q.pop_front();
          if (out_chan.freq_ratio !== exp_est.freq_ratio) begin
            $error("freq_ratio: expected %0d, actual %0d", exp_est.freq_ratio,
                   out_chan.freq_ratio);
            fail_count++;
          end
          if (out_chan.amplitude !== exp_est.amplitude) begin
            $error("amplitude: expected %0d, actual %0d", exp_est.amplitude,
                   out_chan.amplitude);
            fail_count++;
          end
          if (out_chan.div_zero !== exp_est.div_zero) begin
            $error("div_zero: expected %0d, actual %0d", exp_est.div_zero,
                   out_chan.div_zero);
            fail_count++;
          end
          if (out_chan.bad_energy !== exp_est.bad_energy) begin
            $error("bad_energy: expected %0d, actual %0d", exp_est.bad_energy,
                   out_chan.bad_energy);
            fail_count++;
          end
        end
      end
    end
    pending_count = estimate_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the estimator testbench: clock, reset, sample stimulus and result back-pressure.
// Depends on desa2_pkg, desa2_if.sv, the estimator core and desa2_estimate_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   sent_count;
  int   cycle_count;
  logic no_idle;
  logic hold_off;
  logic drained;

  desa2_in_if  in_chan ();
  desa2_out_if out_chan ();

  desa2_frequency_amplitude_estimator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  desa2_estimate_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= !hold_off && (no_idle || ($urandom_range(0, 99) >= 10));
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (sent_count >= 1000);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (600) @(negedge clk);
    hold_off = 1'b0;
  end

  // One sample transfer, with an optional random gap before it.
  task automatic send_sample(input logic signed [desa2_pkg::SAMPLE_BITS-1:0] value);
    @(negedge clk);
    if (!no_idle && ($urandom_range(0, 99) < 10)) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.sample <= value;
    do @(posedge clk); while (!in_chan.ready);
    sent_count++;
  endtask

  // A stretch of sinusoid with random amplitude, frequency and phase.
  task automatic send_tone(input int len);
    real ampl;
    real omega;
    real phase;
    ampl  = $urandom_range(1, 32767);
    omega = $urandom_range(1, 3141) / 1000.0;
    phase = $urandom_range(0, 6283) / 1000.0;
    for (int i = 0; i < len; i++) begin
      send_sample(desa2_pkg::SAMPLE_BITS'($rtoi(ampl * $cos(omega * i + phase))));
    end
  endtask

  initial begin
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    rst_n          = 1'b0;
    no_idle        = 1'b0;
    drained        = 1'b0;
    sent_count     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: startup zeros, constant signal, field extremes, alternating full scale.
    repeat (3) send_sample(16'sd0);
    repeat (5) send_sample(16'sd1234);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sd0);

    // Random: mostly tone segments, some full-range noise.
    while (sent_count < 1420) begin
      no_idle = (sent_count >= 300 && sent_count < 600);
      // Pause once until every expected result has come back.
      if (!drained && sent_count >= 700) begin
        drained = 1'b1;
        @(negedge clk);
        in_chan.valid <= 1'b0;
        wait (pending_count == 0);
      end
      if ($urandom_range(0, 99) < 75) begin
        send_tone($urandom_range(6, 30));
      end else begin
        repeat ($urandom_range(1, 8)) send_sample(desa2_pkg::SAMPLE_BITS'($urandom));
      end
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then allow the block's longest latency.
    wait (pending_count == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/desa2_pkg.sv
hw/rtl/desa2_if.sv
hw/rtl/desa2_sub_unit.sv
hw/rtl/desa2_frequency_amplitude_estimator_core.sv
bench/desa2_estimate_checker.sv
bench/tb_top.sv
